// File: sv/escdec_pkg.sv
// escdec_pkg: shared types, character codes and helpers for the escape text decoder
// no dependencies; imported by escdec_core, escdec_out_reg and escape_text_decoder_top
package escdec_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;   // digit values run 0..35

    // control code mask for caret sequences (octal 037)
    localparam logic [CHAR_W-1:0] CTRL_MASK     = 8'h1F;
    localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 6'd10;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_LOWER_E   = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LOWER_S   = 8'h73;
    localparam logic [CHAR_W-1:0] CH_LOWER_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOWER_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LOWER_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LOWER_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LOWER_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;

    // decoded escape values
    localparam logic [CHAR_W-1:0] BYTE_ESC   = 8'd27;
    localparam logic [CHAR_W-1:0] BYTE_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] BYTE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] BYTE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] BYTE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] BYTE_TAB   = 8'd9;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_CARET  = 3'd2,
        MODE_HEXHI  = 3'd3,
        MODE_HEXLO  = 3'd4
    } decode_mode_t;

    // one decoded beat leaving the core
    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] out_byte;
        logic              out_end;
    } dec_result_t;

    // hex digit value, letters case-folded, anything else is zero
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] diff;
        diff = '0;
        case (ch) inside
            [8'h30:8'h39]: begin
                diff = ch - CH_DIGIT_0;
                return diff[DIGIT_W-1:0];
            end
            [8'h61:8'h7A]: begin
                diff = ch - CH_LOWER_A;
                return diff[DIGIT_W-1:0] + LETTER_OFFSET;
            end
            [8'h41:8'h5A]: begin
                diff = ch - CH_UPPER_A;
                return diff[DIGIT_W-1:0] + LETTER_OFFSET;
            end
            default: return '0;
        endcase
    endfunction

endpackage

// File: sv/escdec_core.sv
// escdec_core: decode mode register, hex high digit register and per-character decode
// depends on escdec_pkg
module escdec_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [escdec_pkg::CHAR_W-1:0] ch,
    output escdec_pkg::dec_result_t      result
);
    import escdec_pkg::*;

    decode_mode_t       mode_reg, mode_next;
    logic [DIGIT_W-1:0] hex_reg, hex_next;
    logic [DIGIT_W-1:0] dval;
    logic [CHAR_W-1:0]  hex_byte;

    assign dval     = digit_value(ch);
    // 16*high + low, modulo 256
    assign hex_byte = {hex_reg[3:0], 4'b0000} + {{(CHAR_W-DIGIT_W){1'b0}}, dval};

    // next state
    always_comb begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        if (ch == CH_NUL) begin
            mode_next = MODE_NORMAL;
            hex_next  = '0;
        end else begin
            case (mode_reg)
                MODE_ESCAPE: begin
                    mode_next = (ch == CH_LOWER_X) ? MODE_HEXHI : MODE_NORMAL;
                end
                MODE_CARET: begin
                    mode_next = MODE_NORMAL;
                end
                MODE_HEXHI: begin
                    mode_next = MODE_HEXLO;
                    hex_next  = dval;
                end
                MODE_HEXLO: begin
                    mode_next = MODE_NORMAL;
                    hex_next  = '0;
                end
                default: begin
                    if (ch == CH_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else if (ch == CH_CARET) begin
                        mode_next = MODE_CARET;
                    end else begin
                        mode_next = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        result.emit     = 1'b0;
        result.out_byte = '0;
        result.out_end  = 1'b0;
        if (ch == CH_NUL) begin
            result.emit    = 1'b1;
            result.out_end = 1'b1;
        end else begin
            case (mode_reg)
                MODE_ESCAPE: begin
                    result.emit = 1'b1;
                    case (ch)
                        CH_LOWER_E:   result.out_byte = BYTE_ESC;
                        CH_LOWER_S:   result.out_byte = BYTE_SPACE;
                        CH_LOWER_B:   result.out_byte = BYTE_BS;
                        CH_LOWER_N:   result.out_byte = BYTE_LF;
                        CH_LOWER_R:   result.out_byte = BYTE_CR;
                        CH_LOWER_T:   result.out_byte = BYTE_TAB;
                        CH_BACKSLASH: result.out_byte = CH_BACKSLASH;
                        CH_CARET:     result.out_byte = CH_CARET;
                        default:      result.emit     = 1'b0;
                    endcase
                end
                MODE_CARET: begin
                    result.emit     = 1'b1;
                    result.out_byte = ch & CTRL_MASK;
                end
                MODE_HEXHI: begin
                    result.emit = 1'b0;
                end
                MODE_HEXLO: begin
                    result.emit     = 1'b1;
                    result.out_byte = hex_byte;
                end
                default: begin
                    result.emit     = (ch != CH_BACKSLASH) && (ch != CH_CARET);
                    result.out_byte = ch;
                end
            endcase
        end
    end

    // state registers, advance once per decoded character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            hex_reg  <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
        end
    end

    // terminator always returns to plain mode with the hex digit cleared
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ch == CH_NUL |=> mode_reg == MODE_NORMAL && hex_reg == '0)
        else $error("terminator did not clear decode state");

    // high hex digit is followed by the low digit unless it is the terminator
    a_hex_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mode_reg == MODE_HEXHI && ch != CH_NUL |=> mode_reg == MODE_HEXLO)
        else $error("hex high digit not followed by low digit mode");

    // low digit mode is only reached from high digit mode
    a_hexlo_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $changed(mode_reg) && mode_reg == MODE_HEXLO |-> $past(mode_reg) == MODE_HEXHI)
        else $error("low digit mode entered out of sequence");

endmodule

// File: sv/escdec_out_reg.sv
// escdec_out_reg: result register holding one decoded beat until taken
// depends on escdec_pkg
module escdec_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  escdec_pkg::dec_result_t       result,
    output logic                          free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [escdec_pkg::CHAR_W-1:0] m_out_byte,
    output logic                          m_out_end
);
    import escdec_pkg::*;

    logic              valid_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic              end_reg;

    // register can take a new beat when empty or being drained this cycle
    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load && result.emit;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (free && load && result.emit) begin
            byte_reg <= result.out_byte;
            end_reg  <= result.out_end;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_end  = end_reg;

endmodule

// File: sv/escape_text_decoder_top.sv
// escape_text_decoder_top: backslash / caret escape decoder, one character per beat
// depends on escdec_pkg, escdec_core, escdec_out_reg
//
//   channel | ports                          | beat carries
//   input   | s_valid s_ready s_in_char      | one string character, 0 ends string
//   result  | m_valid m_ready m_out_byte/end | one raw byte or the terminator
//
// one character per cycle sustained while the result side is not stalled; input register, then result register
// decode sits between the input register and the result register in a single pass
// characters that yield nothing (backslash, caret, x, hex high digit, unknown escape letter) produce no beat
// a stalled result register stalls the input register, which lowers s_ready
// reset clears both valid flags and the decode mode
module escape_text_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [escdec_pkg::CHAR_W-1:0] s_in_char,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [escdec_pkg::CHAR_W-1:0] m_out_byte,
    output logic                          m_out_end
);
    import escdec_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              out_free;
    logic              advance;
    dec_result_t       result;

    // input beat moves into decode when the result register can take it
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_in_char;
        end
    end

    escdec_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .ch      (in_char_reg),
        .result  (result)
    );

    escdec_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result     (result),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_end  (m_out_end)
    );

    // a new result appears only after a character went through decode
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance))
        else $error("result beat without a decoded character");

    // terminator beat carries a zero byte
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_end |-> m_out_byte == '0)
        else $error("terminator beat with nonzero byte");

    // input stage holds while the result side is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_char_reg))
        else $error("input register changed while stalled");

endmodule

// File: tb/sv/escape_text_decoder_top_test.sv
`timescale 1ns / 100ps
// escape_text_decoder_top_test: self-checking bench for the escape text decoder
// depends on escdec_pkg and escape_text_decoder_top; directed table, then random strings
module escape_text_decoder_top_test;

    import escdec_pkg::*;

    localparam int DIRECTED_N     = 25;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int HOLD_AFTER     = 400;   // random items before the long receiver hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,   // checked against the decoder model
        ROW_SILENT,    // no beat expected
        ROW_BYTE,      // plain byte typed in the table
        ROW_END        // terminator beat
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] value;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] value;
        logic              is_end;
    } decoded_beat_t;

    // receiver ready patterns
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } ready_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_in_char = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [CHAR_W-1:0] m_out_byte;
    logic              m_out_end;

    // check kind and typed byte travel with the payload of the current beat
    row_kind_t         cur_kind  = ROW_PREDICT;
    logic [CHAR_W-1:0] cur_value = '0;

    decode_mode_t      model_mode = MODE_NORMAL;
    logic [CHAR_W-1:0] model_hex_high = '0;
    decoded_beat_t     pending_decoded [$];

    stim_row_t         directed_rows [DIRECTED_N];
    logic [CHAR_W-1:0] escape_letters [8];

    int error_count   = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    escape_text_decoder_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_end (m_out_end)
    );

    always #4 aclk = ~aclk;

    // value of a hex digit, letters case-folded, anything else zero
    function automatic logic [CHAR_W-1:0] hex_worth(input logic [CHAR_W-1:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 8'd9)
            return c - CH_DIGIT_0;
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25)
            return c - CH_LOWER_A + CHAR_W'(LETTER_OFFSET);
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25)
            return c - CH_UPPER_A + CHAR_W'(LETTER_OFFSET);
        return '0;
    endfunction

    // decode one character against the model state
    task automatic decode_char(input logic [CHAR_W-1:0] ch, output logic emit,
                               output logic [CHAR_W-1:0] value, output logic is_end);
        emit   = 1'b0;
        value  = '0;
        is_end = 1'b0;
        if (ch == CH_NUL) begin
            model_mode     = MODE_NORMAL;
            model_hex_high = '0;
            emit           = 1'b1;
            is_end         = 1'b1;
        end else begin
            case (model_mode)
                MODE_ESCAPE: begin
                    model_mode = MODE_NORMAL;
                    emit       = 1'b1;
                    case (ch)
                        CH_LOWER_E:   value = BYTE_ESC;
                        CH_LOWER_S:   value = BYTE_SPACE;
                        CH_LOWER_B:   value = BYTE_BS;
                        CH_LOWER_N:   value = BYTE_LF;
                        CH_LOWER_R:   value = BYTE_CR;
                        CH_LOWER_T:   value = BYTE_TAB;
                        CH_BACKSLASH: value = CH_BACKSLASH;
                        CH_CARET:     value = CH_CARET;
                        CH_LOWER_X: begin
                            emit       = 1'b0;
                            model_mode = MODE_HEXHI;
                        end
                        default:      emit = 1'b0;
                    endcase
                end
                MODE_CARET: begin
                    model_mode = MODE_NORMAL;
                    emit       = 1'b1;
                    value      = ch & CTRL_MASK;
                end
                MODE_HEXHI: begin
                    model_hex_high = hex_worth(ch);
                    model_mode     = MODE_HEXLO;
                end
                MODE_HEXLO: begin
                    // high digit times sixteen, modulo 256
                    value          = {model_hex_high[3:0], 4'h0} + hex_worth(ch);
                    emit           = 1'b1;
                    model_mode     = MODE_NORMAL;
                    model_hex_high = '0;
                end
                default: begin
                    model_mode = MODE_NORMAL;
                    if (ch == CH_BACKSLASH) begin
                        model_mode = MODE_ESCAPE;
                    end else if (ch == CH_CARET) begin
                        model_mode = MODE_CARET;
                    end else begin
                        emit  = 1'b1;
                        value = ch;
                    end
                end
            endcase
        end
    endtask

    // offer one character, sender idles between bursts
    task automatic send_char(input logic [CHAR_W-1:0] ch, input row_kind_t kind,
                             input logic [CHAR_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        s_valid   <= 1'b1;
        s_in_char <= ch;
        cur_kind  <= kind;
        cur_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [CHAR_W-1:0] random_digit();
        case ($urandom_range(0, 3))
            0:       return CH_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
            1:       return CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
            2:       return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
            default: return CHAR_W'($urandom_range(1, 255));
        endcase
    endfunction

    // accept monitor, model update, result check and watchdog
    always @(posedge aclk) begin
        logic              p_emit;
        logic [CHAR_W-1:0] p_value;
        logic              p_end;
        decoded_beat_t     exp_beat;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_char(s_in_char, p_emit, p_value, p_end);
                case (cur_kind)
                    ROW_PREDICT: if (p_emit) pending_decoded.push_back('{p_value, p_end});
                    ROW_BYTE:    pending_decoded.push_back('{cur_value, 1'b0});
                    ROW_END:     pending_decoded.push_back('{CH_NUL, 1'b1});
                    default:     ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_decoded.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual byte %02h end %0b",
                             $time, m_out_byte, m_out_end);
                    error_count++;
                end else begin
                    exp_beat = pending_decoded.pop_front();
                    if (m_out_byte !== exp_beat.value) begin
                        $display("%0t: m_out_byte expected %02h actual %02h",
                                 $time, exp_beat.value, m_out_byte);
                        error_count++;
                    end
                    if (m_out_end !== exp_beat.is_end) begin
                        $display("%0t: m_out_end expected %0b actual %0b",
                                 $time, exp_beat.is_end, m_out_end);
                        error_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: one long hold-off on request, otherwise segments of ready patterns
    initial begin : receiver
        ready_mode_t seg_mode;
        int          seg_left;
        seg_mode = READY_ALWAYS;
        seg_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = ready_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (seg_mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    default:      m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int pick;
        int brk;
        directed_rows = '{
            '{ROW_BYTE,    8'hFF,                8'hFF},
            '{ROW_END,     CH_NUL,               8'h00},
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_BYTE,    CH_LOWER_E,           BYTE_ESC},
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_BYTE,    CH_BACKSLASH,         CH_BACKSLASH},
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_BYTE,    CH_CARET,             CH_CARET},
            // hex with both digits case-folded
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_SILENT,  CH_LOWER_X,           8'h00},
            '{ROW_SILENT,  CH_LOWER_A + 8'd5,    8'h00},
            '{ROW_PREDICT, CH_UPPER_A + 8'd5,    8'h00},
            // largest digit values, byte wraps
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_SILENT,  CH_LOWER_X,           8'h00},
            '{ROW_SILENT,  CH_LOWER_A + 8'd25,   8'h00},
            '{ROW_PREDICT, CH_UPPER_A + 8'd25,   8'h00},
            // hex sequence cut off by the terminator
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_SILENT,  CH_LOWER_X,           8'h00},
            '{ROW_END,     CH_NUL,               8'h00},
            // caret then caret is masked too
            '{ROW_SILENT,  CH_CARET,             8'h00},
            '{ROW_BYTE,    CH_CARET,             8'h1E},
            // unknown escape gives nothing
            '{ROW_SILENT,  CH_BACKSLASH,         8'h00},
            '{ROW_SILENT,  CH_LOWER_A + 8'd16,   8'h00},
            // caret cut off by the terminator
            '{ROW_SILENT,  CH_CARET,             8'h00},
            '{ROW_END,     CH_NUL,               8'h00}
        };
        escape_letters = '{CH_LOWER_E, CH_LOWER_S, CH_LOWER_B, CH_LOWER_N,
                           CH_LOWER_R, CH_LOWER_T, CH_BACKSLASH, CH_CARET};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_char(directed_rows[i].ch, directed_rows[i].kind, directed_rows[i].value);

        // random strings, mostly well-formed sequences
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            if (items_sent >= DIRECTED_N + HOLD_AFTER)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_char(CHAR_W'($urandom_range(1, 255)), ROW_PREDICT, '0);
            end else if (pick < 55) begin
                send_char(CH_BACKSLASH, ROW_PREDICT, '0);
                send_char(escape_letters[$urandom_range(0, 7)], ROW_PREDICT, '0);
            end else if (pick < 70) begin
                send_char(CH_BACKSLASH, ROW_PREDICT, '0);
                send_char(CH_LOWER_X, ROW_PREDICT, '0);
                send_char(random_digit(), ROW_PREDICT, '0);
                send_char(random_digit(), ROW_PREDICT, '0);
            end else if (pick < 80) begin
                send_char(CH_CARET, ROW_PREDICT, '0);
                send_char(CHAR_W'($urandom_range(1, 255)), ROW_PREDICT, '0);
            end else if (pick < 88) begin
                send_char(CH_NUL, ROW_PREDICT, '0);
            end else if (pick < 94) begin
                send_char(CHAR_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
            end else begin
                // sequence broken by the terminator
                brk = $urandom_range(0, 3);
                send_char((brk == 1) ? CH_CARET : CH_BACKSLASH, ROW_PREDICT, '0);
                if (brk >= 2)
                    send_char(CH_LOWER_X, ROW_PREDICT, '0);
                if (brk == 3)
                    send_char(random_digit(), ROW_PREDICT, '0);
                send_char(CH_NUL, ROW_PREDICT, '0);
            end
        end
        s_valid <= 1'b0;

        // drain, then wait for any stray beat
        while (pending_decoded.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
